// ===== rtl/srvp_pkg.sv =====
// Shared types and constants of the step rate velocity planner.
package srvp_pkg;

  localparam int TICK_FREQUENCY     = 1000000;
  localparam int RATE_FRACTION_BITS = 32;

  localparam logic [63:0] NS_PER_S    = 64'd1000000000;
  localparam logic [63:0] NS_PER_S_X2 = 64'd2000000000;
  localparam logic [63:0] LIM60       = 64'h1000_0000_0000_0000;
  localparam logic [63:0] RATE_DIV    = 64'(TICK_FREQUENCY) << (32 - RATE_FRACTION_BITS);
  localparam logic [63:0] TICK_WIDE   = 64'(TICK_FREQUENCY);
  localparam logic [63:0] TWO_POW_31  = 64'h0000_0000_8000_0000;
  localparam logic [63:0] FB_ONE      = 64'd65536;

  localparam logic signed [63:0] SMAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN48 = 64'shFFFF_8000_0000_0000;
  localparam logic [47:0]        MAX48  = 48'h7FFF_FFFF_FFFF;

  localparam logic [1:0] CFG_POSITION_SCALE   = 2'd0;
  localparam logic [1:0] CFG_MAX_VELOCITY     = 2'd1;
  localparam logic [1:0] CFG_MAX_ACCELERATION = 2'd2;
  localparam logic [1:0] CFG_SERVO_PERIOD_NS  = 2'd3;

  typedef struct packed {
    logic signed [47:0] position_target;
    logic signed [47:0] velocity_target;
    logic signed [31:0] feedback_count;
    logic               enable_bit;
    logic               velocity_mode;
    logic               reset_position;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] velocity_now;
    logic signed [47:0] position_now;
    logic               direction_forward;
    logic [31:0]        step_rate;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_STEP  = 4'd0,
    OP_DPOS  = 4'd1,
    OP_MAXV  = 4'd2,
    OP_FF    = 4'd3,
    OP_HTV   = 4'd4,
    OP_ETERM = 4'd5,
    OP_NEAR  = 4'd6,
    OP_FAR   = 4'd7,
    OP_VMODE = 4'd8,
    OP_RATE  = 4'd9
  } op_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic vmode;
    logic near;
  } dp_sts_t;

endpackage

// ===== rtl/srvp_mdu.sv =====
// Serial multiply then divide unit: trunc(|a|*b/c), signed, saturated to 2^60.
module srvp_mdu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        a_mag,
  input  logic               neg,
  input  logic [63:0]        mul_b,
  input  logic [63:0]        div_c,
  output logic               done,
  output logic [127:0]       quo,
  output logic [63:0]        rem,
  output logic signed [63:0] res
);
  import srvp_pkg::*;

  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  mcand_r, mcand_nxt, dvsr_r, dvsr_nxt, rem_r, rem_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt, div_ph_r, div_ph_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [64:0]  sum, rs;
  logic         ge;
  logic [63:0]  mag;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    dvsr_nxt   = dvsr_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    div_ph_nxt = div_ph_r;
    done_nxt   = 1'b0;
    neg_nxt    = neg_r;
    sum = {1'b0, acc_r[127:64]} + (acc_r[0] ? {1'b0, mcand_r} : 65'd0);
    rs  = {rem_r, acc_r[127]};
    ge  = rs >= {1'b0, dvsr_r};
    if (start) begin
      acc_nxt    = {64'd0, mul_b};
      mcand_nxt  = a_mag;
      dvsr_nxt   = (div_c == 64'd0) ? 64'd1 : div_c;
      rem_nxt    = 64'd0;
      cnt_nxt    = 7'd0;
      busy_nxt   = 1'b1;
      div_ph_nxt = 1'b0;
      neg_nxt    = neg;
    end else if (busy_r && !div_ph_r) begin
      // shift-add: one multiplier bit per cycle
      acc_nxt = {sum, acc_r[63:1]};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        div_ph_nxt = 1'b1;
        cnt_nxt    = 7'd0;
      end
    end else if (busy_r) begin
      // restoring division: one quotient bit per cycle
      rem_nxt = ge ? 64'(rs - {1'b0, dvsr_r}) : rs[63:0];
      acc_nxt = {acc_r[126:0], ge};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd127) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    dvsr_r  <= dvsr_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    if (!rst_n) begin
      cnt_r    <= 7'd0;
      busy_r   <= 1'b0;
      div_ph_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      busy_r   <= busy_nxt;
      div_ph_r <= div_ph_nxt;
      done_r   <= done_nxt;
    end
  end

  always_comb begin
    mag = ((acc_r[127:64] != 64'd0) || (acc_r[63:0] > LIM60)) ? LIM60 : acc_r[63:0];
    res = neg_r ? -signed'(mag) : signed'(mag);
  end

  assign done = done_r;
  assign quo  = acc_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/srvp_ctrl.sv =====
// Sequencer that steps the datapath through the planning operations.
module srvp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  srvp_pkg::dp_sts_t sts,
  output srvp_pkg::dp_cmd_t cmd
);
  import srvp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt, op_follow;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    case (op_r)
      OP_STEP:  op_follow = OP_DPOS;
      OP_DPOS:  op_follow = OP_MAXV;
      OP_MAXV:  op_follow = sts.vmode ? OP_VMODE : OP_FF;
      OP_FF:    op_follow = OP_HTV;
      OP_HTV:   op_follow = OP_ETERM;
      OP_ETERM: op_follow = sts.near ? OP_NEAR : OP_FAR;
      default:  op_follow = OP_RATE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd           = '0;
    cmd.op        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = OP_STEP;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.exec = 1'b1;
        if (op_r == OP_VMODE) begin
          op_nxt = OP_RATE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.unit_done) begin
          if (op_r == OP_RATE) begin
            state_nxt = ST_EMIT;
          end else begin
            op_nxt    = op_follow;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_STEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/srvp_dp.sv =====
// Datapath: configuration, axis state, operand selection and writeback.
module srvp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  srvp_pkg::dp_cmd_t   cmd,
  output srvp_pkg::dp_sts_t   sts,
  input  srvp_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [46:0]         cfg_data,
  output srvp_pkg::out_item_t out_item
);
  import srvp_pkg::*;

  // configuration
  logic signed [31:0] scale_r;
  logic [46:0]        maxvel_r, maxacc_r;
  logic [26:0]        period_r;

  // axis state
  logic signed [47:0] lpt_r, vfb_r, pos_r;
  logic [31:0]        lfb_r;

  // current item and temporaries
  logic signed [47:0] pcmd_r, vcmd_r;
  logic signed [31:0] dd_r;
  logic               en_r, vmode_r, preset_r;
  logic [47:0]        step_r, maxv_r;
  logic               step_rem_r;
  logic signed [63:0] ff_r, htv_r, e_r, vel_r;
  logic [31:0]        rate_r;
  logic               fwd_r;
  out_item_t          out_r;

  logic               s_zero, s_neg, acc_pos;
  logic [31:0]        a_s;
  logic [26:0]        per;
  logic signed [63:0] verr, step_s, maxv_s, velc, op_a, mres;
  logic [63:0]        av, op_b, op_c, a_mag;
  logic               near;
  logic               unit_done;
  logic [127:0]       quo;
  logic [63:0]        rem;

  logic signed [63:0] dpos, psum, pos_sat, vnear, vfar, delta, ef, vvm, diff;
  logic [47:0]        ph, maxv_new;
  logic               rnd;
  logic [64:0]        qr;
  logic [31:0]        rate_new;

  always_comb begin
    s_zero  = (scale_r == 32'sd0);
    s_neg   = scale_r[31];
    a_s     = s_neg ? 32'(-scale_r) : 32'(scale_r);
    per     = (period_r == 27'd0) ? 27'd1 : period_r;
    acc_pos = (maxacc_r != 47'd0);
    verr    = 64'(vfb_r) - ff_r;
    av      = verr[63] ? 64'(-verr) : 64'(verr);
    step_s  = signed'({16'd0, step_r});
    maxv_s  = signed'({16'd0, maxv_r});
    // av*1e9 < A*P is the same as av below the acceleration step quotient
    near    = (verr == 64'sd0) ||
              (acc_pos && ((av < {16'd0, step_r}) || (av == {16'd0, step_r} && step_rem_r)));
    velc    = vel_r;
    if (velc > maxv_s) velc = maxv_s;
    if (velc < -maxv_s) velc = -maxv_s;
  end

  always_comb begin
    op_a = 64'sd0;
    op_b = 64'd0;
    op_c = 64'd1;
    case (cmd.op)
      OP_STEP: begin
        op_a = signed'({17'd0, maxacc_r});
        op_b = {37'd0, per};
        op_c = NS_PER_S;
      end
      OP_DPOS: begin
        op_a = 64'(dd_r);
        op_b = FB_ONE;
        op_c = {32'd0, a_s};
      end
      OP_MAXV: begin
        op_a = signed'(TICK_WIDE);
        op_b = TWO_POW_31;
        op_c = {32'd0, a_s};
      end
      OP_FF: begin
        op_a = 64'(pcmd_r) - 64'(lpt_r);
        op_b = NS_PER_S;
        op_c = {37'd0, per};
      end
      OP_HTV: begin
        op_a = verr;
        op_b = acc_pos ? av : {37'd0, per};
        op_c = acc_pos ? {16'd0, maxacc_r, 1'b0} : NS_PER_S_X2;
      end
      OP_ETERM: begin
        op_a = ff_r + 64'(vfb_r);
        op_b = {37'd0, per};
        op_c = NS_PER_S_X2;
      end
      OP_NEAR: begin
        op_a = e_r;
        op_b = NS_PER_S;
        op_c = {36'd0, per, 1'b0};
      end
      OP_FAR: begin
        op_a = verr;
        op_b = {35'd0, per, 2'b00};
        op_c = NS_PER_S;
      end
      OP_RATE: begin
        op_a = velc;
        op_b = {32'd0, a_s};
        op_c = RATE_DIV;
      end
      default: begin
        op_a = 64'sd0;
      end
    endcase
    a_mag = op_a[63] ? 64'(-op_a) : 64'(op_a);
  end

  srvp_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.exec && (cmd.op != OP_VMODE)),
    .a_mag (a_mag),
    .neg   (op_a[63]),
    .mul_b (op_b),
    .div_c (op_c),
    .done  (unit_done),
    .quo   (quo),
    .rem   (rem),
    .res   (mres)
  );

  // writeback values
  always_comb begin
    dpos = s_zero ? 64'sd0 : (s_neg ? -mres : mres);
    psum = 64'(pos_r) + dpos;
    pos_sat = psum;
    if (psum > SMAX48) pos_sat = SMAX48;
    if (psum < SMIN48) pos_sat = SMIN48;

    ph = (s_zero || mres > SMAX48) ? MAX48 : mres[47:0];
    maxv_new = ((maxvel_r != 47'd0) && ({1'b0, maxvel_r} < ph)) ? {1'b0, maxvel_r} : ph;

    vnear = ff_r - mres;
    if (acc_pos) begin
      if (vnear < 64'(vfb_r) - step_s) vnear = 64'(vfb_r) - step_s;
      if (vnear > 64'(vfb_r) + step_s) vnear = 64'(vfb_r) + step_s;
    end

    delta = !acc_pos ? -verr : ((verr > 64'sd0) ? -step_s : step_s);
    ef    = e_r + mres;
    if ((ef[63] ? 64'(-ef) : 64'(ef)) < (e_r[63] ? 64'(-e_r) : 64'(e_r))) delta = -delta;
    vfar  = 64'(vfb_r) + delta;

    diff = 64'(vcmd_r) - 64'(vfb_r);
    vvm  = 64'(vcmd_r);
    if (acc_pos) begin
      if (diff > step_s) vvm = 64'(vfb_r) + step_s;
      else if (diff < -step_s) vvm = 64'(vfb_r) - step_s;
    end

    // round half up on the remainder
    rnd = rem >= (RATE_DIV - rem);
    qr  = {1'b0, quo[63:0]} + {64'd0, rnd};
    rate_new = ((quo[127:64] != 64'd0) || (qr > 65'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : qr[31:0];
    if (!en_r) rate_new = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 32'sd65536;
      maxvel_r <= 47'd0;
      maxacc_r <= 47'd65536;
      period_r <= 27'd1000000;
      lpt_r    <= 48'sd0;
      vfb_r    <= 48'sd0;
      pos_r    <= 48'sd0;
      lfb_r    <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POSITION_SCALE:   scale_r  <= signed'(cfg_data[31:0]);
          CFG_MAX_VELOCITY:     maxvel_r <= cfg_data;
          CFG_MAX_ACCELERATION: maxacc_r <= cfg_data;
          CFG_SERVO_PERIOD_NS:  period_r <= cfg_data[26:0];
          default:              period_r <= period_r;
        endcase
      end
      if (cmd.load) begin
        lfb_r <= in_item.feedback_count;
      end
      if (unit_done) begin
        case (cmd.op)
          OP_DPOS: pos_r <= preset_r ? 48'sd0 : pos_sat[47:0];
          OP_FF:   lpt_r <= pcmd_r;
          OP_RATE: vfb_r <= velc[47:0];
          default: lpt_r <= lpt_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pcmd_r   <= in_item.position_target;
      vcmd_r   <= in_item.velocity_target;
      dd_r     <= signed'(in_item.feedback_count - lfb_r);
      en_r     <= in_item.enable_bit;
      vmode_r  <= in_item.velocity_mode;
      preset_r <= in_item.reset_position;
    end
    if (cmd.exec && cmd.op == OP_VMODE) begin
      vel_r <= vvm;
    end
    if (unit_done) begin
      case (cmd.op)
        OP_STEP: begin
          step_r     <= mres[47:0];
          step_rem_r <= (rem != 64'd0);
        end
        OP_MAXV:  maxv_r <= maxv_new;
        OP_FF:    ff_r   <= mres;
        OP_HTV:   htv_r  <= mres;
        OP_ETERM: e_r    <= 64'(pos_r) - 64'(pcmd_r) + mres + htv_r;
        OP_NEAR:  vel_r  <= vnear;
        OP_FAR:   vel_r  <= vfar;
        OP_RATE: begin
          rate_r <= rate_new;
          fwd_r  <= (velc == 64'sd0) || s_zero || (velc[63] == s_neg);
        end
        default: fwd_r <= fwd_r;
      endcase
    end
    if (cmd.emit) begin
      out_r.velocity_now      <= vfb_r;
      out_r.position_now      <= pos_r;
      out_r.direction_forward <= fwd_r;
      out_r.step_rate         <= rate_r;
    end
  end

  assign sts.unit_done = unit_done;
  assign sts.vmode     = vmode_r;
  assign sts.near      = near;
  assign out_item      = out_r;

endmodule

// ===== rtl/step_rate_velocity_planner.sv =====
// Items are planned one at a time: a new input is taken only while the planner is idle.
// Each multiply-divide holds the shared serial unit (issue, 64 multiply steps, 128 divide steps,
// done); position mode runs eight of them, velocity mode four.
// The next item is taken while a result still waits for out_ready.
// Reset (synchronous, rst_n low): configuration returns to its defaults and the
// position, velocity, last target and last feedback state clear to zero.
module step_rate_velocity_planner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srvp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output srvp_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [46:0]         cfg_data
);
  import srvp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  srvp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srvp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/srvp_checker.sv =====
// Port checker for the planner and its bind to the top level.
module srvp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input srvp_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input srvp_pkg::out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input changed before transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed before transfer");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_rose_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while the planner is still busy");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("planner not idle after reset");

endmodule

bind step_rate_velocity_planner srvp_checker u_srvp_checker (.*);
